>>> rtl/core/assert_macros.svh
// Assertion macros used by the interval selector sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GIS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define GIS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define GIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/gis_pkg.sv
// Shared types and constants of the greedy interval selector.
package gis_pkg;

    // Width of the count field in a result transaction.
    localparam int COUNT_W = 7;

    // Result tdata layout, from the lowest bit up.
    localparam int OUT_ACC_BIT  = 0;
    localparam int OUT_CNT_LSB  = 1;
    localparam int OUT_FULL_BIT = OUT_CNT_LSB + COUNT_W;
    localparam int OUT_DATA_W   = ((OUT_FULL_BIT + 1 + 7) / 8) * 8;

    // Outcome of one pass through the shared compare unit.
    typedef struct packed {
        logic start_lt_finish;  // new start lies before the stored finish
        logic finish_gt_start;  // new finish lies after the stored start
    } cmp_result_t;

endpackage

>>> rtl/core/gis_cmp.sv
// Shared compare unit: checks a new interval against one stored interval.
module gis_cmp
    import gis_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic [TIME_BITS-1:0] new_start,
    input  logic [TIME_BITS-1:0] new_finish,
    input  logic [TIME_BITS-1:0] old_start,
    input  logic [TIME_BITS-1:0] old_finish,
    output cmp_result_t          result
);

    // Both half-open overlap terms; last-only mode uses the first alone.
    assign result.start_lt_finish = (new_start < old_finish);
    assign result.finish_gt_start = (new_finish > old_start);

endmodule

>>> rtl/core/gis_store.sv
// Selection store: one write port and one registered read port.
module gis_store #(
    parameter int DEPTH     = 64,
    parameter int TIME_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [TIME_BITS-1:0]     wr_start,
    input  logic [TIME_BITS-1:0]     wr_finish,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [TIME_BITS-1:0]     rd_start,
    output logic [TIME_BITS-1:0]     rd_finish
);

    logic [2*TIME_BITS-1:0] mem [DEPTH];
    logic [2*TIME_BITS-1:0] rd_data_reg;

    // Entries hold {finish, start}; the read data is registered.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_finish, wr_start};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_start  = rd_data_reg[TIME_BITS-1:0];
    assign rd_finish = rd_data_reg[2*TIME_BITS-1:TIME_BITS];

endmodule

>>> rtl/core/gis_ctrl.sv
// Sequencer of the interval selector: walks the store through the compare unit.
`include "assert_macros.svh"

module gis_ctrl
    import gis_pkg::*;
#(
    parameter int SEL_DEPTH = 64,
    parameter int TIME_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         check_mode,
    // Input transaction
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [TIME_BITS-1:0]         s_start,
    input  logic [TIME_BITS-1:0]         s_finish,
    input  logic                         s_last,
    // Store ports
    output logic                         wr_en,
    output logic [$clog2(SEL_DEPTH)-1:0] wr_addr,
    output logic [TIME_BITS-1:0]         wr_start,
    output logic [TIME_BITS-1:0]         wr_finish,
    output logic [$clog2(SEL_DEPTH)-1:0] rd_addr,
    input  logic [TIME_BITS-1:0]         rd_start,
    input  logic [TIME_BITS-1:0]         rd_finish,
    // Result transaction
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic                         m_accepted,
    output logic [COUNT_W-1:0]           m_count,
    output logic                         m_full,
    output logic                         m_last
);

    localparam int AW    = $clog2(SEL_DEPTH);
    localparam int CNT_W = $clog2(SEL_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t               state_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] finish_reg;
    logic                 last_reg;
    logic [CNT_W-1:0]     total_reg;
    logic                 in_run_reg;
    logic [AW-1:0]        cmp_idx_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic                 compat_reg;
    logic                 out_valid_reg;
    logic                 out_acc_reg;
    logic [COUNT_W-1:0]   out_cnt_reg;
    logic                 out_full_reg;
    logic                 out_last_reg;

    logic [CNT_W-1:0]         total_eff;
    logic [CNT_W-1:0]         total_eff_m1;
    logic [CNT_W-1:0]         total_m1;
    logic                     has_room;
    logic                     out_free;
    logic                     commit;
    logic                     take;
    logic [CNT_W-1:0]         total_next;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;
    cmp_result_t              cmp_res;

    // The shared compare unit sees the held interval and the entry just read.
    gis_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .new_start  (start_reg),
        .new_finish (finish_reg),
        .old_start  (rd_start),
        .old_finish (rd_finish),
        .result     (cmp_res)
    );

    // Count as seen by a new item, and the decision terms.
    always_comb begin
        total_eff    = in_run_reg ? total_reg : '0;
        total_eff_m1 = total_eff - CNT_W'(1);
        total_m1     = total_reg - CNT_W'(1);
        has_room     = (total_reg < CNT_W'(SEL_DEPTH));
        out_free     = !out_valid_reg || m_tready;
        commit       = (state_reg == ST_DECIDE) && out_free;
        take         = compat_reg && has_room;
        total_next   = total_reg + CNT_W'(take);
        cnt_ext      = {{COUNT_W{1'b0}}, total_next};
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign rd_addr   = rd_addr_reg;
    assign wr_en     = commit && take;
    assign wr_addr   = total_reg[AW-1:0];
    assign wr_start  = start_reg;
    assign wr_finish = finish_reg;

    assign m_tvalid   = out_valid_reg;
    assign m_accepted = out_acc_reg;
    assign m_count    = out_cnt_reg;
    assign m_full     = out_full_reg;
    assign m_last     = out_last_reg;

    // Sequencer state and the registered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            in_run_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // The result leaves unless a new one replaces it in the same cycle.
            if (out_valid_reg && m_tready && !commit) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        start_reg  <= s_start;
                        finish_reg <= s_finish;
                        last_reg   <= s_last;
                        total_reg  <= total_eff;
                        if (total_eff == '0) begin
                            // First interval of a run is always compatible.
                            compat_reg <= 1'b1;
                            state_reg  <= ST_DECIDE;
                        end else if (check_mode) begin
                            cmp_idx_reg <= '0;
                            rd_addr_reg <= '0;
                            state_reg   <= ST_FETCH;
                        end else begin
                            cmp_idx_reg <= total_eff_m1[AW-1:0];
                            rd_addr_reg <= total_eff_m1[AW-1:0];
                            state_reg   <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    // The first entry is on its way; address the one after it.
                    rd_addr_reg <= rd_addr_reg + AW'(1);
                    state_reg   <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (!check_mode) begin
                        compat_reg <= !cmp_res.start_lt_finish;
                        state_reg  <= ST_DECIDE;
                    end else if (cmp_res.start_lt_finish && cmp_res.finish_gt_start) begin
                        compat_reg <= 1'b0;
                        state_reg  <= ST_DECIDE;
                    end else if (CNT_W'(cmp_idx_reg) == total_m1) begin
                        compat_reg <= 1'b1;
                        state_reg  <= ST_DECIDE;
                    end else begin
                        cmp_idx_reg <= cmp_idx_reg + AW'(1);
                        rd_addr_reg <= rd_addr_reg + AW'(1);
                    end
                end
                ST_DECIDE: begin
                    // Commit once the result register is free.
                    if (out_free) begin
                        total_reg     <= total_next;
                        in_run_reg    <= !last_reg;
                        out_valid_reg <= 1'b1;
                        out_acc_reg   <= take;
                        out_full_reg  <= compat_reg && !has_room;
                        out_cnt_reg   <= cnt_ext[COUNT_W-1:0];
                        out_last_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `GIS_ASSERT(a_total_bound, aclk, aresetn, total_reg <= CNT_W'(SEL_DEPTH), "count beyond store depth")
    `GIS_ASSERT_IMPL(a_acc_full_excl, aclk, aresetn, out_valid_reg, !(out_acc_reg && out_full_reg), "accepted and full together")
    `GIS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready held after an accepted transaction")
    `GIS_ASSERT_IMPL(a_write_in_range, aclk, aresetn, wr_en, total_reg < CNT_W'(SEL_DEPTH), "store write with no room")

endmodule

>>> rtl/core/greedy_interval_selector.sv
// Greedy interval selector: top level with configuration and stream ports.
// Each item runs to its commit before the next is taken. First interval of a run: straight
// to the decide step. Last-only mode: fetch, scan, decide, with one store read.
// Check-all mode: fetch, then n entries compared one per cycle in the scan, at most SEL_DEPTH,
// then decide. A waiting result holds the next item at its commit.
// aresetn (synchronous, active low) clears the count, run flag, check_mode and the output valid.
module greedy_interval_selector
    import gis_pkg::*;
#(
    parameter int SEL_DEPTH = 64,
    parameter int TIME_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write: check_mode
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_data,
    // Input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: interval start, interval finish, zero padding (lowest bit up)
    input  logic [((2*TIME_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                  s_tlast,
    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: accepted, selected_count, store_full, zero padding (lowest bit up)
    output logic [OUT_DATA_W-1:0]                 m_tdata,
    output logic                                  m_tlast
);

    localparam int AW = $clog2(SEL_DEPTH);

    logic                 check_mode_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [TIME_BITS-1:0] wr_start;
    logic [TIME_BITS-1:0] wr_finish;
    logic [AW-1:0]        rd_addr;
    logic [TIME_BITS-1:0] rd_start;
    logic [TIME_BITS-1:0] rd_finish;
    logic                 res_acc;
    logic [COUNT_W-1:0]   res_cnt;
    logic                 res_full;

    // Configuration register, written only while the block is idle and no input is offered.
    assign cfg_ready = s_tready && !s_tvalid;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            check_mode_reg <= cfg_data;
        end
    end

    gis_store #(
        .DEPTH     (SEL_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_start  (wr_start),
        .wr_finish (wr_finish),
        .rd_addr   (rd_addr),
        .rd_start  (rd_start),
        .rd_finish (rd_finish)
    );

    gis_ctrl #(
        .SEL_DEPTH (SEL_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .check_mode (check_mode_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_start    (s_tdata[TIME_BITS-1:0]),
        .s_finish   (s_tdata[2*TIME_BITS-1:TIME_BITS]),
        .s_last     (s_tlast),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_start   (wr_start),
        .wr_finish  (wr_finish),
        .rd_addr    (rd_addr),
        .rd_start   (rd_start),
        .rd_finish  (rd_finish),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_accepted (res_acc),
        .m_count    (res_cnt),
        .m_full     (res_full),
        .m_last     (m_tlast)
    );

    // Pack the result fields into tdata.
    always_comb begin
        m_tdata                                  = '0;
        m_tdata[OUT_ACC_BIT]                     = res_acc;
        m_tdata[OUT_CNT_LSB +: COUNT_W]          = res_cnt;
        m_tdata[OUT_FULL_BIT]                    = res_full;
    end

endmodule
